### hw/rtl/cfs_pkg.sv
// Shared types and constants for the closest fraction search block.
package cfs_pkg;

  // Input value word and the fixed-point layout defaults
  localparam int unsigned VALUE_W         = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned DENOM_BITS_DEF  = 10;

  // Largest denominator tried after reset
  localparam int unsigned MAX_DENOM_RESET = 1000;

  // Search sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } cfs_state_e;

endpackage

### hw/rtl/closest_fraction_search_top.sv
// Top level of the closest fraction search: sequencer, shared compare unit, output register.

// Each input word carries a signed fixed-point value with FRAC_BITS fraction bits. The block
// walks the denominators b = 1 .. max_denominator (0 counts as 1) and returns the fraction
// a/b nearest to the value, with a = floor(x*b) or floor(x*b)+1. Errors are compared exactly
// by cross-multiplication; only a strictly closer candidate replaces the best, so ties keep
// the smaller denominator and, for one b, the floor numerator. One denominator is checked
// per cycle by a single compare unit. After a word is accepted, the search state walks b up
// to limit = max_denominator (0 counts as 1), the finish state loads the result into the
// output register, and the idle state follows before the next word can be taken; a new
// word is taken only once the search is over. The finished result sits in an output
// register, so a new search starts while it waits; if that register still holds an untaken
// result when a search ends, the search waits until it is taken.
// max_denominator may only be written while no search is running.
module closest_fraction_search_top
  import cfs_pkg::*;
#(
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned DENOM_BITS = DENOM_BITS_DEF,
  localparam int unsigned NUM_BITS  = VALUE_W - FRAC_BITS + DENOM_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [DENOM_BITS-1:0]        cfg_wdata_i,
  // input words
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [VALUE_W-1:0]    value_i,
  input  logic                         last_in_i,
  // result words
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [NUM_BITS-1:0]   numerator_o,
  output logic [DENOM_BITS-1:0]        denominator_o,
  output logic                         last_out_o
);

  localparam int unsigned P_W    = VALUE_W + DENOM_BITS;
  localparam int unsigned PROD_W = FRAC_BITS + DENOM_BITS;
  localparam logic [FRAC_BITS:0]   ONE_FIX    = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] HALF_FIX   = FRAC_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [DENOM_BITS-1:0] DENOM_ONE = DENOM_BITS'(1);

  cfs_state_e state_q, state_d;

  logic [DENOM_BITS-1:0]      max_denom_q;
  logic [DENOM_BITS-1:0]      limit;
  logic signed [P_W-1:0]      p_q;
  logic signed [P_W-1:0]      v_q;
  logic [DENOM_BITS-1:0]      b_q;
  logic                       last_q;
  logic signed [NUM_BITS-1:0] best_a_q;
  logic [DENOM_BITS-1:0]      best_b_q;
  logic [FRAC_BITS-1:0]       best_e_q;

  logic                       out_valid_q;
  logic signed [NUM_BITS-1:0] numerator_q;
  logic [DENOM_BITS-1:0]      denominator_q;
  logic                       last_out_q;

  logic                       accept;
  logic                       load_out;
  logic signed [NUM_BITS-1:0] a_floor;
  logic [FRAC_BITS-1:0]       e_lo;
  logic [FRAC_BITS:0]         e_hi;
  logic                       ceil_sel;
  logic [FRAC_BITS-1:0]       e_min;
  logic signed [NUM_BITS-1:0] a_cand;
  logic [PROD_W-1:0]          prod_cand;
  logic [PROD_W-1:0]          prod_best;
  logic                       take;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_denom_q <= DENOM_BITS'(MAX_DENOM_RESET);
    end else if (cfg_we_i) begin
      max_denom_q <= cfg_wdata_i;
    end
  end

  // Treat a zero limit as one
  assign limit = (max_denom_q == '0) ? DENOM_ONE : max_denom_q;

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and handshake
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (b_q == limit) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  // Candidate pair for the current denominator: p = value * b
  assign a_floor  = p_q[P_W-1:FRAC_BITS];
  assign e_lo     = p_q[FRAC_BITS-1:0];
  assign e_hi     = ONE_FIX - {1'b0, e_lo};
  assign ceil_sel = e_hi < {1'b0, e_lo};
  assign e_min    = ceil_sel ? e_hi[FRAC_BITS-1:0] : e_lo;
  assign a_cand   = a_floor + NUM_BITS'(ceil_sel);

  // Shared compare unit: e_min / b < best_e / best_b by cross-multiplication
  assign prod_cand = PROD_W'(e_min) * PROD_W'(best_b_q);
  assign prod_best = PROD_W'(best_e_q) * PROD_W'(b_q);
  assign take      = (b_q == DENOM_ONE) || (prod_cand < prod_best);

  // Search datapath: load on accept, advance one denominator per cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_q    <= {{DENOM_BITS{value_i[VALUE_W-1]}}, value_i};
      v_q    <= {{DENOM_BITS{value_i[VALUE_W-1]}}, value_i};
      b_q    <= DENOM_ONE;
      last_q <= last_in_i;
    end else if (state_q == ST_SEARCH) begin
      p_q <= p_q + v_q;
      b_q <= b_q + DENOM_ONE;
      if (take) begin
        best_a_q <= a_cand;
        best_b_q <= b_q;
        best_e_q <= e_min;
      end
    end
  end

  // Output register: hold the result until the word is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      numerator_q   <= best_a_q;
      denominator_q <= best_b_q;
      last_out_q    <= last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign numerator_o   = numerator_q;
  assign denominator_o = denominator_q;
  assign last_out_o    = last_out_q;

  // The denominator counter stays inside the search range
  a_b_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (b_q != '0) && (b_q <= limit))
    else $error("denominator counter out of range");

  // The nearer numerator is never more than half a step away
  a_best_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |-> (best_e_q <= HALF_FIX) && (best_b_q != '0))
    else $error("best error or denominator out of range");

  // A new result appears only right after a finished search
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result loaded outside the finish step");

endmodule
